[rtl/lru_page_table_lookup_macros.svh]
// Assertion macros shared by the page table lookup RTL.
// In synthesis builds the macros expand to nothing.
`ifndef LRU_PAGE_TABLE_LOOKUP_MACROS_SVH
`define LRU_PAGE_TABLE_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define LPT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define LPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LPT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define LPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/lpt_pkg.sv]
package lpt_pkg;

   localparam int PAGE_BITS  = 20;
   localparam int FRAME_BITS = 10;
   localparam int COUNT_BITS = 32;

   // One lookup request.
   typedef struct packed {
      logic [PAGE_BITS-1:0]  page_number;
      logic [FRAME_BITS-1:0] new_frame;
   } lpt_req_type;

   // One lookup response.
   typedef struct packed {
      logic [FRAME_BITS-1:0] frame_number;
      logic                  page_fault;
      logic [COUNT_BITS-1:0] fault_count;
   } lpt_rsp_type;

   // Status that ripples from each cell to its right-hand neighbor.
   typedef struct packed {
      logic                  hit_seen;
      logic                  empty_seen;
      logic [FRAME_BITS-1:0] hit_frame;
   } lpt_chain_type;

   // Decision broadcast back to every cell from the end of the row.
   typedef struct packed {
      logic update;
      logic any_hit;
      logic any_empty;
   } lpt_decide_type;

endpackage

[rtl/lpt_cell.sv]
module lpt_cell #(
   parameter int RANK_BITS = 2,
   parameter int INDEX     = 0,
   parameter int LAST_RANK = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpt_pkg::lpt_req_type   req,
   input  lpt_pkg::lpt_decide_type decide,
   input  logic [RANK_BITS-1:0]   touch_rank,
   input  lpt_pkg::lpt_chain_type chain_in,
   input  logic [RANK_BITS-1:0]   hit_rank_in,
   input  logic [RANK_BITS-1:0]   empty_rank_in,
   output lpt_pkg::lpt_chain_type chain_out,
   output logic [RANK_BITS-1:0]   hit_rank_out,
   output logic [RANK_BITS-1:0]   empty_rank_out
);
   import lpt_pkg::*;

   logic [PAGE_BITS-1:0]  page_ff,  page_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  valid_ff, valid_in;
   logic [RANK_BITS-1:0]  rank_ff,  rank_in;

   logic my_hit;
   logic first_empty;
   logic victim;
   logic touch;

   always_comb begin
      my_hit      = valid_ff && (page_ff == req.page_number);
      first_empty = !valid_ff && !chain_in.empty_seen;

      chain_out.hit_seen   = chain_in.hit_seen | my_hit;
      chain_out.empty_seen = chain_in.empty_seen | !valid_ff;
      chain_out.hit_frame  = my_hit ? frame_ff : chain_in.hit_frame;
      hit_rank_out         = my_hit ? rank_ff : hit_rank_in;
      empty_rank_out       = first_empty ? rank_ff : empty_rank_in;

      // On a miss the victim is the first empty entry, else the least recent one.
      victim = !decide.any_hit &&
               (decide.any_empty ? first_empty : (rank_ff == '0));
      touch  = my_hit | victim;

      page_in  = page_ff;
      frame_in = frame_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (decide.update) begin
         if (touch) begin
            rank_in = RANK_BITS'(LAST_RANK);
         end else if (rank_ff > touch_rank) begin
            rank_in = rank_ff - 1'b1;
         end
         if (victim) begin
            page_in  = req.page_number;
            frame_in = req.new_frame;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= RANK_BITS'(INDEX);
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      page_ff  <= page_in;
      frame_ff <= frame_in;
   end

endmodule

[rtl/lru_page_table_lookup.sv]
// Channel   Direction  Ports                               Contents
// request   in         req_valid, req_stall, req_data      page number, spare frame
// response  out        rsp_valid, rsp_stall, rsp_data      frame, fault flag, fault count
//
// A request transaction is registered at acceptance and resolved into the response
// output register once that register can take it, so one transaction per cycle
// is sustained while the response side does not stall.
// The table is a row of cells; hit, first-empty and rank information ripple along
// the row combinationally, which sets the critical path for larger ENTRIES.
// Reset is synchronous: the table comes up empty with ranks in entry order and the
// fault counter at zero. A stalled response holds the pending request in place.
`include "lru_page_table_lookup_macros.svh"

module lru_page_table_lookup #(
   parameter int ENTRIES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lpt_pkg::lpt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpt_pkg::lpt_rsp_type rsp_data
);
   import lpt_pkg::*;

   localparam int RANK_BITS = $clog2(ENTRIES);
   localparam int LAST_RANK = ENTRIES - 1;

   // Pending request register between acceptance and table update.
   logic        pend_ff, pend_in;
   lpt_req_type req_ff,  req_in;

   // Response output register.
   logic        rsp_valid_ff, rsp_valid_in;
   lpt_rsp_type rsp_ff,       rsp_in;

   // Saturating count of page faults.
   logic [COUNT_BITS-1:0] fault_total_ff, fault_total_in;
   logic [COUNT_BITS-1:0] fault_next;

   logic accept;
   logic advance;

   // Signals that ripple along the row of cells.
   lpt_chain_type        chain      [ENTRIES+1];
   logic [RANK_BITS-1:0] hit_rank   [ENTRIES+1];
   logic [RANK_BITS-1:0] empty_rank [ENTRIES+1];

   lpt_decide_type       decide;
   logic [RANK_BITS-1:0] touch_rank;

   assign chain[0]      = '0;
   assign hit_rank[0]   = '0;
   assign empty_rank[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         lpt_cell #(
            .RANK_BITS (RANK_BITS),
            .INDEX     (gi),
            .LAST_RANK (LAST_RANK)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .req            (req_ff),
            .decide         (decide),
            .touch_rank     (touch_rank),
            .chain_in       (chain[gi]),
            .hit_rank_in    (hit_rank[gi]),
            .empty_rank_in  (empty_rank[gi]),
            .chain_out      (chain[gi+1]),
            .hit_rank_out   (hit_rank[gi+1]),
            .empty_rank_out (empty_rank[gi+1])
         );
      end
   endgenerate

   always_comb begin
      // The pending transaction resolves once the response register can take it.
      advance   = pend_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = pend_ff && !advance;
      accept    = req_valid && !req_stall;

      decide.update    = advance;
      decide.any_hit   = chain[ENTRIES].hit_seen;
      decide.any_empty = chain[ENTRIES].empty_seen;

      // Old rank of the entry that becomes most recent; entries above it shift down.
      if (decide.any_hit) begin
         touch_rank = hit_rank[ENTRIES];
      end else if (decide.any_empty) begin
         touch_rank = empty_rank[ENTRIES];
      end else begin
         touch_rank = '0;
      end

      fault_next = (fault_total_ff == '1) ? fault_total_ff : fault_total_ff + 1'b1;

      pend_in = accept | (pend_ff & !advance);
      req_in  = accept ? req_data : req_ff;

      fault_total_in = fault_total_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (decide.any_hit) begin
            rsp_in.frame_number = chain[ENTRIES].hit_frame;
            rsp_in.page_fault   = 1'b0;
            rsp_in.fault_count  = fault_total_ff;
         end else begin
            rsp_in.frame_number = req_ff.new_frame;
            rsp_in.page_fault   = 1'b1;
            rsp_in.fault_count  = fault_next;
            fault_total_in      = fault_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fault_total_ff <= '0;
      end else begin
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         fault_total_ff <= fault_total_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A resolved transaction always lands in the response register.
   `LPT_ASSERT_NEXT(a_advance_to_rsp, clock, reset, advance, rsp_valid_ff, "resolved transaction lost")
   // A held request keeps its contents until it resolves.
   `LPT_ASSERT_NEXT(a_pend_hold, clock, reset, pend_ff && !advance, pend_ff && $stable(req_ff), "pending request changed")
   // The fault counter never moves backward.
   `LPT_ASSERT_NEXT(a_count_monotonic, clock, reset, 1'b1, fault_total_ff >= $past(fault_total_ff), "fault count decreased")
   // A faulting response always carries a nonzero count.
   `LPT_ASSERT_SAME(a_fault_count, clock, reset, rsp_valid_ff && rsp_ff.page_fault, rsp_ff.fault_count != '0, "fault with zero count")

endmodule

[tb/sv/tb_lru_page_table_lookup.sv]
`timescale 1ns / 100ps

module tb_lru_page_table_lookup;

   import lpt_pkg::*;

   // Geometry of the table under test; it matches the default of the block.
   localparam int TABLE_SLOTS = 4;

   // Cycles the response side holds off during its long stall. This is far longer
   // than the pending and response registers can absorb, so the block must back up and stall its input.
   localparam int unsigned LONG_HOLD = 60;

   // Cycles with outstanding work but no accepted transaction before the run is declared hung.
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   // Number of random references after the directed part.
   localparam int RANDOM_REFS = 1430;

   // One page reference waiting to be sent. The gap is the number of idle cycles
   // the sender spends before offering it; when drain_first is set, the sender
   // also waits until every outstanding translation has come back.
   typedef struct {
      lpt_req_type data;
      int unsigned gap;
      bit          drain_first;
   } page_ref_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lpt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lpt_rsp_type rsp_data;

   // References not yet offered, and translations predicted but not yet returned.
   page_ref_type ref_queue[$];
   lpt_rsp_type  expected_translations[$];

   // Handshake outcomes of the last rising edge, read by the falling-edge drivers.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   int unsigned translations_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned recv_wait = 0;
   int unsigned idle_cycles = 0;

   // Shadow copy of the page table: pages, frames, valid bits, an exact recency
   // order (0 is least recent, TABLE_SLOTS-1 most recent) and the fault counter.
   logic [PAGE_BITS-1:0]  shadow_page [TABLE_SLOTS];
   logic [FRAME_BITS-1:0] shadow_frame[TABLE_SLOTS];
   logic                  shadow_valid[TABLE_SLOTS];
   int unsigned           shadow_rank [TABLE_SLOTS];
   logic [COUNT_BITS-1:0] shadow_faults;

   lru_page_table_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Makes one slot the most recent. Every slot ranked above it moves down one
   // place, so the ranks always remain a permutation of 0..TABLE_SLOTS-1.
   function automatic void promote(int slot);
      int unsigned old_rank;
      old_rank = shadow_rank[slot];
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (shadow_rank[i] > old_rank) begin
            shadow_rank[i] = shadow_rank[i] - 1;
         end
      end
      shadow_rank[slot] = TABLE_SLOTS - 1;
   endfunction

   // Looks one reference up in the shadow table, updates the table exactly as the
   // block must, and returns the translation the block has to produce.
   function automatic lpt_rsp_type translate(lpt_req_type r);
      lpt_rsp_type res;
      int          hit_slot;
      int          victim;
      hit_slot = -1;
      victim = -1;
      // Slots that are not valid never hit, whatever page they still hold.
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (hit_slot < 0 && shadow_valid[i] && shadow_page[i] == r.page_number) begin
            hit_slot = i;
         end
      end
      if (hit_slot >= 0) begin
         promote(hit_slot);
         res.frame_number = shadow_frame[hit_slot];
         res.page_fault = 1'b0;
         res.fault_count = shadow_faults;
         return res;
      end
      // A fault: the counter saturates at its maximum instead of wrapping.
      if (shadow_faults != '1) begin
         shadow_faults = shadow_faults + 1'b1;
      end
      // The victim is the lowest empty slot, or else the least recent one.
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (victim < 0 && !shadow_valid[i]) begin
            victim = i;
         end
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (victim < 0 && shadow_rank[i] == 0) begin
            victim = i;
         end
      end
      shadow_page[victim] = r.page_number;
      shadow_frame[victim] = r.new_frame;
      shadow_valid[victim] = 1'b1;
      promote(victim);
      res.frame_number = r.new_frame;
      res.page_fault = 1'b1;
      res.fault_count = shadow_faults;
      return res;
   endfunction

   task automatic add_ref(input logic [PAGE_BITS-1:0] page, input logic [FRAME_BITS-1:0] frame,
                          input int unsigned gap, input bit drain_first);
      page_ref_type item;
      item.data.page_number = page;
      item.data.new_frame = frame;
      item.gap = gap;
      item.drain_first = drain_first;
      ref_queue.push_back(item);
   endtask

   // Monitor. Samples both channels at the rising edge. A returned translation is
   // checked against the oldest prediction before a newly accepted reference adds
   // its own prediction, so the two can never be confused within one edge.
   always @(posedge clock) begin
      lpt_rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            shadow_page[i] = '0;
            shadow_frame[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i] = i;
         end
         shadow_faults = '0;
         expected_translations.delete();
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            translations_seen = translations_seen + 1;
            if (expected_translations.size() == 0) begin
               $error("translation returned with none outstanding: frame %0d fault %0d count %0d",
                      rsp_data.frame_number, rsp_data.page_fault, rsp_data.fault_count);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_translations.pop_front();
               if (rsp_data.frame_number !== want.frame_number) begin
                  $error("frame_number: expected %0d, actual %0d",
                         want.frame_number, rsp_data.frame_number);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_data.page_fault !== want.page_fault) begin
                  $error("page_fault: expected %0d, actual %0d",
                         want.page_fault, rsp_data.page_fault);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_data.fault_count !== want.fault_count) begin
                  $error("fault_count: expected %0d, actual %0d",
                         want.fault_count, rsp_data.fault_count);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_translations.push_back(translate(req_data));
         end
      end
   end

   // Driver. Works at the falling edge from the outcome of the last rising edge.
   // A new reference is only taken once the current one has been accepted, so a
   // stalled payload never changes and valid never looks at the stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (ref_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (ref_queue[0].gap != 0) begin
            ref_queue[0].gap = ref_queue[0].gap - 1;
            req_valid <= 1'b0;
         end else if (ref_queue[0].drain_first && expected_translations.size() != 0) begin
            // Pause until every outstanding translation has come back.
            req_valid <= 1'b0;
         end else begin
            req_data <= ref_queue[0].data;
            req_valid <= 1'b1;
            void'(ref_queue.pop_front());
         end
      end
   end

   // Receiver. After each accepted translation it draws how long to stall before
   // taking the next one. Twice in the run it holds off for a long stretch while
   // the sender keeps offering references, and in every fourth block of 250
   // translations it never stalls at all.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_fire) begin
            if (translations_seen == 400 || translations_seen == 1000) begin
               recv_wait = LONG_HOLD;
            end else if ((translations_seen / 250) % 4 == 3) begin
               recv_wait = 0;
            end else begin
               recv_wait = $urandom_range(0, 4);
            end
         end
         rsp_stall <= (recv_wait != 0);
         if (recv_wait != 0) begin
            recv_wait = recv_wait - 1;
         end
      end
   end

   // Watchdog. Counts cycles in which work is outstanding yet no transaction
   // moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (ref_queue.size() == 0 && expected_translations.size() == 0 && !req_valid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [PAGE_BITS-1:0] hot_pages[6];
      logic [PAGE_BITS-1:0] page;
      int unsigned          gap;
      int unsigned          pick;

      // Directed part. The table starts empty, and the shadow's empty slots hold
      // page 0, so the first reference to page 0 must fault rather than hit.
      add_ref(20'h00000, 10'h3FF, 0, 1'b0);   // page 0 into an empty table
      add_ref(20'h00000, 10'h005, 0, 1'b0);   // hit returns the stored frame
      add_ref(20'hFFFFF, 10'h000, 0, 1'b0);   // largest page, smallest frame
      add_ref(20'h12345, 10'h155, 1, 1'b0);
      add_ref(20'hEDCBA, 10'h2AA, 0, 1'b0);   // table now full
      add_ref(20'hFFFFF, 10'h111, 0, 1'b0);   // hit in the middle of the order
      add_ref(20'h00001, 10'h001, 0, 1'b0);   // evicts the least recent slot
      add_ref(20'h00000, 10'h200, 2, 1'b0);   // evicted page faults again
      add_ref(20'h12345, 10'h3FE, 0, 1'b0);
      add_ref(20'hFFFFF, 10'h0F0, 0, 1'b0);
      add_ref(20'hFFFFE, 10'h3C3, 0, 1'b0);   // one bit away from a resident page
      add_ref(20'hFFFFE, 10'h000, 0, 1'b0);
      add_ref(20'h00000, 10'h000, 0, 1'b0);
      add_ref(20'h12345, 10'h000, 3, 1'b0);
      add_ref(20'hFFFFE, 10'h000, 0, 1'b0);   // makes the slot most recent for the next reference
      add_ref(20'hFFFFE, 10'h000, 0, 1'b0);
      add_ref(20'h80000, 10'h200, 0, 1'b0);   // top page bit alone
      add_ref(20'h00000, 10'h3FF, 4, 1'b0);
      add_ref(20'h7FFFF, 10'h1FF, 0, 1'b0);
      add_ref(20'h80000, 10'h000, 0, 1'b0);

      // Random part. Most references come from a small set of hot pages, a
      // little larger than the table, so that hits, promotions and evictions
      // all happen often. The set is refreshed now and then, and the rest are
      // pages drawn from the whole range or near misses of a hot page.
      foreach (hot_pages[i]) begin
         hot_pages[i] = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
      end
      for (int n = 0; n < RANDOM_REFS; n++) begin
         if ($urandom_range(0, 39) == 0) begin
            hot_pages[$urandom_range(0, 5)] = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            page = hot_pages[$urandom_range(0, 4 + (n / 500) % 2)];
         end else if (pick < 85) begin
            page = hot_pages[$urandom_range(0, 5)] ^ (20'h1 << $urandom_range(0, PAGE_BITS - 1));
         end else begin
            page = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
         end
         // Every fourth block of 150 references goes out back to back.
         gap = ((n / 150) % 4 == 2) ? 0 : $urandom_range(0, 4);
         add_ref(page, FRAME_BITS'($urandom_range(0, 10'h3FF)), gap, (n % 300) == 0);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (ref_queue.size() != 0 || req_valid || expected_translations.size() != 0) begin
         @(posedge clock);
      end
      // Keep the clock running so that any stray translation is caught.
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
